FILE: rtl/rdf_pkg.sv
// shared constants, types and helpers for the radix digit formatter
package rdf_pkg;

  localparam int unsigned MAX_RADIX   = 16;
  localparam int unsigned VALUE_BITS  = 64;
  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned NUM_SYMS    = 16;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned RADIX_W     = 5;
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned REM_W       = $clog2(MAX_RADIX);
  localparam int unsigned SYM_IDX_W   = $clog2(NUM_SYMS);
  localparam int unsigned STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned COUNT_W     = $clog2(STORE_DEPTH + 1);
  // quotient bits retired per clock in the divider
  localparam int unsigned STEP_BITS   = 4;
  localparam int unsigned STEPS       = VALUE_BITS / STEP_BITS;
  localparam int unsigned STEP_CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMS_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMS_HI  = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RESET    = 5'd10;
  localparam logic [CFG_W-1:0]   SYMS_LOW_RESET = 64'h3736_3534_3332_3130;
  localparam logic [CFG_W-1:0]   SYMS_HI_RESET  = 64'h0000_0000_0000_4539;

  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] PRINT_LO = 8'd32;
  localparam logic [SYM_W-1:0] PRINT_HI = 8'd126;

  typedef logic [NUM_SYMS*SYM_W-1:0] alphabet_t;

  typedef struct packed {
    logic load;   // capture a new dividend
    logic start;  // run one division pass on the held quotient
  } div_ctl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             quot_zero;
    logic [REM_W-1:0] rem;
  } div_stat_t;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_stat_t;

  function automatic logic [SYM_W-1:0] alpha_byte(alphabet_t syms,
                                                  logic [SYM_IDX_W-1:0] idx);
    alpha_byte = syms[idx*SYM_W +: SYM_W];
  endfunction

endpackage

FILE: rtl/rdf_alpha_check.sv
// sequential alphabet checker, one symbol against all later symbols below the radix per clock
module rdf_alpha_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [4:0]         radix_i,
  input  rdf_pkg::alphabet_t syms_i,
  output rdf_pkg::chk_stat_t stat_o
);
  import rdf_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 ok_q, ok_d;
  logic [SYM_IDX_W-1:0] idx_q, idx_d;
  logic [SYM_W-1:0]     cur;
  logic                 bad_sym;
  logic                 dup;
  logic                 last_idx;
  logic                 radix_bad;

  assign cur       = alpha_byte(syms_i, idx_q);
  assign radix_bad = (radix_i < RADIX_W'(2)) || (radix_i > RADIX_W'(MAX_RADIX));
  assign last_idx  = (RADIX_W'(idx_q) + RADIX_W'(1)) == radix_i;
  assign bad_sym   = (cur == CH_PLUS) || (cur == CH_MINUS) ||
                     (cur < PRINT_LO) || (cur > PRINT_HI);

  always_comb begin
    dup = 1'b0;
    for (int unsigned j = 0; j < NUM_SYMS; j++) begin
      if ((SYM_IDX_W'(j) > idx_q) && (RADIX_W'(j) < radix_i) &&
          (alpha_byte(syms_i, SYM_IDX_W'(j)) == cur)) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ok_d   = ok_q;
    idx_d  = idx_q;
    if (start_i) begin
      idx_d = '0;
      if (radix_bad) begin
        done_d = 1'b1;
        ok_d   = 1'b0;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (bad_sym || dup) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        ok_d   = 1'b0;
      end else if (last_idx) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        ok_d   = 1'b1;
      end else begin
        idx_d = idx_q + SYM_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ok_q   <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ok_q   <= ok_d;
      idx_q  <= idx_d;
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.ok   = ok_q;

endmodule

FILE: rtl/rdf_divider.sv
// digit-serial divider by the radix, STEP_BITS quotient bits per clock
module rdf_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rdf_pkg::div_ctl_t               ctl_i,
  input  logic [rdf_pkg::VALUE_BITS-1:0]  value_i,
  input  logic [4:0]                      radix_i,
  output rdf_pkg::div_stat_t              stat_o
);
  import rdf_pkg::*;

  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [STEP_CNT_W-1:0] step_q, step_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [VALUE_BITS-1:0] qs;
  logic [REM_W-1:0]      r;
  logic [RADIX_W-1:0]    t;

  // restoring division, quotient bits shift in as dividend bits shift out
  always_comb begin
    qs = quot_q;
    r  = rem_q;
    t  = '0;
    for (int unsigned i = 0; i < STEP_BITS; i++) begin
      t  = RADIX_W'({r, qs[VALUE_BITS-1]});
      qs = {qs[VALUE_BITS-2:0], 1'b0};
      if (t >= radix_i) begin
        qs[0] = 1'b1;
        t     = t - radix_i;
      end
      r = t[REM_W-1:0];
    end
  end

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.load) begin
      quot_d = value_i;
    end else if (ctl_i.start) begin
      rem_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = qs;
      rem_d  = r;
      step_d = step_q + STEP_CNT_W'(1);
      if (step_q == STEP_CNT_W'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      rem_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign stat_o.busy      = busy_q;
  assign stat_o.done      = done_q;
  assign stat_o.quot_zero = (quot_q == '0);
  assign stat_o.rem       = rem_q;

endmodule

FILE: rtl/radix_digit_formatter.sv
// top level: unsigned value to symbol string in a configurable radix
// One value is taken at a time. The alphabet check walks the symbols in turn
// (at most 16), each digit costs one division pass (4 quotient bits per clock
// over the 64-bit quotient), and each digit is then read from the digit store
// and sent through the output register. A zero value or a rejected alphabet
// gives one beat after the check. The next value is taken once the last beat
// of a run sits in the output register.
module radix_digit_formatter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rdf_pkg::VALUE_BITS-1:0] s_axis_tdata,  // [63:0] value
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rdf_pkg::SYM_W-1:0]      m_axis_tdata,  // [7:0] symbol
  output logic                           m_axis_tlast,  // last
  output logic                           m_axis_tuser,  // [0] invalid
  input  logic                           cfg_we_i,
  input  logic [rdf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rdf_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import rdf_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_DIV     = 3'd2;
  localparam logic [2:0] ST_EMIT_RD = 3'd3;
  localparam logic [2:0] ST_EMIT_WR = 3'd4;
  localparam logic [2:0] ST_ONE     = 3'd5;

  logic [RADIX_W-1:0]     radix_q;
  logic [CFG_W-1:0]       syms_lo_q;
  logic [CFG_W-1:0]       syms_hi_q;
  alphabet_t              syms;

  logic [2:0]             state_q, state_d;
  logic [COUNT_W-1:0]     cnt_q, cnt_d;
  logic [STORE_IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [REM_W-1:0]       digit_mem [STORE_DEPTH];
  logic [REM_W-1:0]       rdata_q;
  logic                   mem_we;

  logic                   one_inv_q, one_inv_d;

  logic                   out_valid_q, out_valid_d;
  logic [SYM_W-1:0]       out_sym_q, out_sym_d;
  logic                   out_last_q, out_last_d;
  logic                   out_inv_q, out_inv_d;
  logic                   out_free;

  logic                   accept;
  logic                   chk_start;
  chk_stat_t              chk_stat;
  div_ctl_t               div_ctl;
  div_stat_t              div_stat;

  assign syms     = {syms_hi_q, syms_lo_q};
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q   <= RADIX_RESET;
      syms_lo_q <= SYMS_LOW_RESET;
      syms_hi_q <= SYMS_HI_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RADIX:    radix_q   <= cfg_wdata_i[RADIX_W-1:0];
        REG_SYMS_LOW: syms_lo_q <= cfg_wdata_i;
        REG_SYMS_HI:  syms_hi_q <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  rdf_alpha_check u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (chk_start),
    .radix_i (radix_q),
    .syms_i  (syms),
    .stat_o  (chk_stat)
  );

  rdf_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (div_ctl),
    .value_i (s_axis_tdata),
    .radix_i (radix_q),
    .stat_o  (div_stat)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    one_inv_d   = one_inv_q;
    chk_start   = 1'b0;
    div_ctl     = '0;
    mem_we      = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;
    out_inv_d   = out_inv_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          div_ctl.load = 1'b1;
          chk_start    = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk_stat.done) begin
          if (!chk_stat.ok) begin
            one_inv_d = 1'b1;
            state_d   = ST_ONE;
          end else if (div_stat.quot_zero) begin
            one_inv_d = 1'b0;
            state_d   = ST_ONE;
          end else begin
            cnt_d         = '0;
            div_ctl.start = 1'b1;
            state_d       = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + COUNT_W'(1);
          if (!div_stat.quot_zero && (cnt_q != COUNT_W'(STORE_DEPTH - 1))) begin
            div_ctl.start = 1'b1;
          end else begin
            rd_idx_d = cnt_q[STORE_IDX_W-1:0];
            state_d  = ST_EMIT_RD;
          end
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = alpha_byte(syms, SYM_IDX_W'(rdata_q));
          out_last_d  = (rd_idx_q == '0);
          out_inv_d   = 1'b0;
          if (rd_idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q - STORE_IDX_W'(1);
            state_d  = ST_EMIT_RD;
          end
        end
      end
      ST_ONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = one_inv_q ? '0 : CH_ZERO;
          out_last_d  = 1'b1;
          out_inv_d   = one_inv_q;
          if (!one_inv_q) begin
            cnt_d = COUNT_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      one_inv_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      one_inv_q   <= one_inv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
    out_inv_q  <= out_inv_d;
  end

  // digit store, least significant digit at entry 0
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[cnt_q[STORE_IDX_W-1:0]] <= div_stat.rem;
    end
    rdata_q <= digit_mem[rd_idx_q];
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sym_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_inv_q;

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_CHECK))
    else $error("accepted value did not start the alphabet check");

  a_invalid_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)))
    else $error("invalid beat must be a lone last beat with symbol zero");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q < COUNT_W'(STORE_DEPTH)))
    else $error("digit count ran past the store depth");

  a_last_digit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT_WR) && out_free && (rd_idx_q == '0))
      |=> (m_axis_tvalid && m_axis_tlast && (state_q == ST_IDLE)))
    else $error("final digit did not close the run");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == ST_DIV))
    else $error("divider running outside the division phase");

endmodule

FILE: bench/radix_digit_formatter_checker.sv
// checker for the radix digit formatter: predicts symbol beats and compares them
`timescale 1ns / 1ps

module radix_digit_formatter_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [rdf_pkg::VALUE_BITS-1:0] s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [rdf_pkg::SYM_W-1:0]      m_axis_tdata,
  input  logic                           m_axis_tlast,
  input  logic                           m_axis_tuser,
  input  logic                           cfg_we_i,
  input  logic [rdf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rdf_pkg::CFG_W-1:0]      cfg_wdata_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             values_o,
  output int                             symbols_o,
  output int                             rejects_o
);
  import rdf_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             invalid;
  } symbol_beat_t;

  symbol_beat_t     expected_symbols[$];
  logic [RADIX_W-1:0] radix_q;
  logic [CFG_W-1:0]   syms_lo_q;
  logic [CFG_W-1:0]   syms_hi_q;

  function automatic symbol_beat_t beat(input logic [SYM_W-1:0] sym, input logic lst,
                                        input logic inv);
    symbol_beat_t b;
    b.symbol  = sym;
    b.last    = lst;
    b.invalid = inv;
    return b;
  endfunction

  function automatic logic [SYM_W-1:0] symbol_at(input int unsigned idx);
    logic [2*CFG_W-1:0] alpha_bits;
    alpha_bits = {syms_hi_q, syms_lo_q};
    return alpha_bits[(idx % NUM_SYMS)*SYM_W +: SYM_W];
  endfunction

  function automatic bit alphabet_ok();
    int unsigned n;
    logic [SYM_W-1:0] c;
    n = radix_q;
    if (n < 2 || n > MAX_RADIX) return 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      c = symbol_at(i);
      if (c == CH_PLUS || c == CH_MINUS) return 1'b0;
      if (c < PRINT_LO || c > PRINT_HI) return 1'b0;
      for (int unsigned j = i + 1; j < n; j++)
        if (symbol_at(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // digits are found least significant first and sent most significant first
  function automatic void predict_digits(input logic [VALUE_BITS-1:0] value);
    logic [REM_W-1:0]      digits[STORE_DEPTH];
    int unsigned           count;
    logic [VALUE_BITS-1:0] quot;
    logic [VALUE_BITS-1:0] base;
    if (!alphabet_ok()) begin
      expected_symbols.push_back(beat('0, 1'b1, 1'b1));
      return;
    end
    if (value == '0) begin
      expected_symbols.push_back(beat(CH_ZERO, 1'b1, 1'b0));
      return;
    end
    base  = VALUE_BITS'(radix_q);
    quot  = value;
    count = 0;
    while (quot != '0 && count < STORE_DEPTH) begin
      digits[count] = REM_W'(quot % base);
      quot = quot / base;
      count++;
    end
    for (int unsigned k = 0; k < count; k++)
      expected_symbols.push_back(beat(symbol_at(digits[count-1-k]), k + 1 == count, 1'b0));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    symbol_beat_t want;
    int           errs;
    if (!rst_ni) begin
      radix_q      <= RADIX_RESET;
      syms_lo_q    <= SYMS_LOW_RESET;
      syms_hi_q    <= SYMS_HI_RESET;
      fail_count_o <= 0;
      pending_o    <= 0;
      values_o     <= 0;
      symbols_o    <= 0;
      rejects_o    <= 0;
      expected_symbols.delete();
    end else begin
      errs = 0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RADIX:    radix_q   <= cfg_wdata_i[RADIX_W-1:0];
          REG_SYMS_LOW: syms_lo_q <= cfg_wdata_i;
          REG_SYMS_HI:  syms_hi_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (!alphabet_ok()) rejects_o <= rejects_o + 1;
        predict_digits(s_axis_tdata);
        values_o <= values_o + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        symbols_o <= symbols_o + 1;
        if (expected_symbols.size() == 0) begin
          $error("beat with nothing expected: symbol %02h last %0b invalid %0b",
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
          errs++;
        end else begin
          want = expected_symbols.pop_front();
          if (m_axis_tdata !== want.symbol) begin
            $error("symbol mismatch: expected %02h, got %02h", want.symbol, m_axis_tdata);
            errs++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, m_axis_tlast);
            errs++;
          end
          if (m_axis_tuser !== want.invalid) begin
            $error("invalid mismatch: expected %0b, got %0b", want.invalid, m_axis_tuser);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= expected_symbols.size();
    end
  end

endmodule

FILE: bench/radix_digit_formatter_test.sv
// testbench top for the radix digit formatter: stimulus, alphabet setup and verdict
`timescale 1ns / 1ps

module radix_digit_formatter_test;
  import rdf_pkg::*;

  localparam int ITEMS         = 360;
  localparam int CALM_ITEMS    = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 20;
  localparam int STALL_LIMIT   = 20000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    BAD_PLUS, BAD_MINUS, BAD_DUP, BAD_LOW, BAD_HIGH, BAD_SHORT, BAD_LONG
  } bad_kind_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [VALUE_BITS-1:0] s_axis_tdata;   // [63:0] value
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [SYM_W-1:0]      m_axis_tdata;   // [7:0] symbol
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;   // [0] invalid
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_wdata_i;

  int fail_count, pending, values, symbols, rejects;
  int sent, settings, stall_cycles;
  bit calm, idle_on, hold_req;

  radix_digit_formatter dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  radix_digit_formatter_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending), .values_o(values),
    .symbols_o(symbols), .rejects_o(rejects)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // nothing accepted on either side for too long means the block hung
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else if (stall_cycles >= STALL_LIMIT) begin
      $display("no beat for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    bit held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held          = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        m_axis_tready = 1'b1;
      end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // radix goes in with random upper bits, only the low five count
  task automatic apply_alphabet(input logic [RADIX_W-1:0] radix,
                                input logic [2*CFG_W-1:0] alpha);
    logic [CFG_W-1:0] radix_word;
    radix_word = {$urandom, $urandom};
    radix_word[RADIX_W-1:0] = radix;
    write_reg(REG_RADIX, radix_word);
    write_reg(REG_SYMS_LOW, alpha[CFG_W-1:0]);
    write_reg(REG_SYMS_HI, alpha[2*CFG_W-1:CFG_W]);
    settings++;
  endtask

  // distinct printable symbols below the radix, anything above it
  function automatic logic [2*CFG_W-1:0] make_alphabet(input int unsigned radix);
    logic [2*CFG_W-1:0] alpha;
    logic [255:0]       used;
    logic [SYM_W-1:0]   c;
    alpha = {$urandom, $urandom, $urandom, $urandom};
    used  = '0;
    for (int unsigned i = 0; i < radix; i++) begin
      do c = SYM_W'($urandom_range(PRINT_LO, PRINT_HI));
      while (used[c] || c == CH_PLUS || c == CH_MINUS);
      used[c] = 1'b1;
      alpha[i*SYM_W +: SYM_W] = c;
    end
    return alpha;
  endfunction

  task automatic apply_broken(input bad_kind_e kind, input bit at_bound);
    int unsigned        radix, pos, other;
    logic [2*CFG_W-1:0] alpha;
    radix = $urandom_range(2, MAX_RADIX);
    alpha = make_alphabet(radix);
    pos   = $urandom_range(0, radix - 1);
    case (kind)
      BAD_PLUS:  alpha[pos*SYM_W +: SYM_W] = CH_PLUS;
      BAD_MINUS: alpha[pos*SYM_W +: SYM_W] = CH_MINUS;
      BAD_DUP: begin
        other = (pos + $urandom_range(1, radix - 1)) % radix;
        alpha[pos*SYM_W +: SYM_W] = alpha[other*SYM_W +: SYM_W];
      end
      BAD_LOW:   alpha[pos*SYM_W +: SYM_W] = at_bound ? PRINT_LO - SYM_W'(1) :
                                             SYM_W'($urandom_range(0, PRINT_LO - 1));
      BAD_HIGH:  alpha[pos*SYM_W +: SYM_W] = at_bound ? PRINT_HI + SYM_W'(1) :
                                             SYM_W'($urandom_range(PRINT_HI + 1, 255));
      BAD_SHORT: radix = at_bound ? 1 : 0;
      BAD_LONG:  radix = at_bound ? MAX_RADIX + 1 : $urandom_range(MAX_RADIX + 2, 31);
      default: ;
    endcase
    apply_alphabet(RADIX_W'(radix), alpha);
  endtask

  task automatic push_value(input logic [VALUE_BITS-1:0] value);
    calm = (sent >= ITEMS - CALM_ITEMS);
    if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    sent++;
  endtask

  // block is idle once every expected beat is out
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // mostly short values so that radix 2 runs stay cheap
  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [VALUE_BITS-1:0] v;
    int unsigned           pick, len;
    v    = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 4) return '0;
    if (pick < 8) return v | {1'b1, {(VALUE_BITS-1){1'b0}}};
    len = (pick < 80) ? $urandom_range(1, 24) : $urandom_range(25, VALUE_BITS - 1);
    return v >> (VALUE_BITS - len);
  endfunction

  initial begin
    int unsigned radix, count, phase;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_RADIX;
    cfg_wdata_i   = '0;
    calm          = 1'b0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    sent          = 0;
    settings      = 1;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset alphabet is radix 10 with symbols 0 to 7, then 9 and E
    push_value('0);
    push_value(64'd1);
    push_value(64'd9);
    push_value(64'd10);
    push_value('1);
    push_value(64'h8000_0000_0000_0000);
    push_value(64'd10000000000000000000);
    drain();

    // write to the unused index must leave the alphabet alone
    write_reg(REG_UNUSED, {$urandom, $urandom});
    apply_alphabet(RADIX_W'(2), make_alphabet(2));
    push_value('1);
    push_value('0);
    push_value(64'd1);
    push_value(64'h8000_0000_0000_0000);
    drain();

    // hex with the printable bounds, space and tilde, as symbols
    apply_alphabet(RADIX_W'(MAX_RADIX),
                   {64'h7E65_6463_6261_3938, 64'h3736_3534_3332_3120});
    push_value('1);
    push_value(64'h0123_4567_89AB_CDEF);
    push_value('0);
    drain();

    for (int k = BAD_PLUS; k <= BAD_LONG; k++) begin
      apply_broken(bad_kind_e'(k), 1'b1);
      push_value(k == BAD_SHORT ? '0 : random_value());
      drain();
    end

    phase = 0;
    while (sent < ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 6) == 0)
        apply_broken(bad_kind_e'(3'($urandom_range(BAD_PLUS, BAD_LONG))),
                     1'($urandom_range(0, 1)));
      else begin
        case ($urandom_range(0, 6))
          0:       radix = 2;
          1:       radix = MAX_RADIX;
          default: radix = $urandom_range(2, MAX_RADIX);
        endcase
        apply_alphabet(RADIX_W'(radix), make_alphabet(radix));
      end
      if (phase == 2) hold_req = 1'b1;
      count = $urandom_range(10, 40);
      repeat (count) push_value(random_value());
      drain();
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (pending != 0) $error("%0d expected beats never arrived", pending);
    $display("%0d values over %0d alphabet settings, %0d against rejected alphabets",
             values, settings, rejects);
    $display("%0d symbol beats checked, with one receiver hold-off of %0d cycles",
             symbols, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
